@@ rtl/tfn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg
// Types and widths shared by the triangle facet normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int CoordW = 16;
  localparam int EdgeW  = 17;
  localparam int ProdW  = 34;
  localparam int CrossW = 35;
  localparam int MagW   = 34;
  localparam int SqW    = 68;
  localparam int SumW   = 69;
  localparam int ResW   = 100;
  localparam int KW     = 15;
  localparam int OutW   = 16;
  localparam int FracShift = 30;
  localparam int NumIter = 15;

  typedef struct packed {
    logic signed [ResW-1:0] r;
    logic signed [ResW-1:0] p;
    logic [KW-1:0]          k;
    logic                   neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]     lane;
    logic [SumW-1:0] s;
    logic            zero;
    logic            last;
  } iter_t;

endpackage

@@ rtl/tfn_iter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_iter
// One digit step of the normalizing divide for all three components.
// ----------------------------------------------------------------------------
module tfn_iter #(
  parameter int BIT = 14
) (
  input  logic          clk,
  input  logic          en,
  input  tfn_pkg::iter_t d,
  output tfn_pkg::iter_t q_r
);

  tfn_pkg::iter_t q_nxt;
  logic signed [tfn_pkg::ResW-1:0] s_ext;
  logic signed [tfn_pkg::ResW-1:0] term [3];
  logic signed [tfn_pkg::ResW-1:0] diff [3];

  always_comb begin
    q_nxt = d;
    s_ext = $signed({{(tfn_pkg::ResW - tfn_pkg::SumW){1'b0}}, d.s});
    for (int i = 0; i < 3; i++) begin
      term[i] = (d.lane[i].p <<< (BIT + 2)) + (s_ext <<< (2 * BIT + 2));
      diff[i] = d.lane[i].r - term[i];
      if (!diff[i][tfn_pkg::ResW-1]) begin
        q_nxt.lane[i].r = diff[i];
        q_nxt.lane[i].p = d.lane[i].p + (s_ext <<< (BIT + 1));
        q_nxt.lane[i].k = d.lane[i].k | tfn_pkg::KW'(1 << BIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

@@ rtl/triangle_facet_normal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_facet_normal
// Unit facet normal of a triangle, exact nearest rounding to Q1.14.
// ----------------------------------------------------------------------------
// The block takes one triangle per cycle and presents one normal per cycle,
// both while out_tready does not stall the pipe. Five stages form the
// edges, the cross product, its squares and their sum; fifteen stages each
// settle one bit of every component by a shift-and-subtract compare; a last
// stage applies the sign. A stall holds each full stage and lets empty stages
// fill.
module triangle_facet_normal (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [143:0] in_tdata,  // ax, ay, az, bx, by_coord, bz, cx, cy, cz
  input  logic        in_tlast,   // tri_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // nx, ny, nz
  output logic        out_tlast   // normal_last
);

  localparam int NS = 21;
  localparam int IT0 = 4;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;
  logic [NS-1:0] ld;

  logic signed [tfn_pkg::EdgeW-1:0] u_r [3];
  logic signed [tfn_pkg::EdgeW-1:0] w_r [3];
  logic signed [tfn_pkg::ProdW-1:0] m_r [6];
  logic signed [tfn_pkg::CrossW-1:0] c_r [3];
  logic [tfn_pkg::SqW-1:0] sq_r [3];
  logic [2:0] neg_r;
  logic [3:0] last_r;
  logic [tfn_pkg::MagW-1:0] mag [3];
  logic signed [tfn_pkg::CoordW-1:0] vin [9];
  logic [tfn_pkg::SumW-1:0] s_sum;
  tfn_pkg::iter_t it0_nxt;
  tfn_pkg::iter_t it_r [tfn_pkg::NumIter+1];
  logic [tfn_pkg::OutW-1:0] o_r [3];
  logic o_last_r;

  always_comb begin
    rdy[NS] = out_tready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    ld[0] = rdy[0] && in_tvalid;
    for (int i = 1; i < NS; i++) begin
      ld[i] = rdy[i] && v_r[i-1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      vin[i] = $signed(in_tdata[16*i +: 16]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= tfn_pkg::EdgeW'(vin[3+i]) - tfn_pkg::EdgeW'(vin[i]);
        w_r[i] <= tfn_pkg::EdgeW'(vin[6+i]) - tfn_pkg::EdgeW'(vin[i]);
      end
      last_r[0] <= in_tlast;
    end
    if (ld[1]) begin
      m_r[0] <= u_r[1] * w_r[2];
      m_r[1] <= u_r[2] * w_r[1];
      m_r[2] <= u_r[2] * w_r[0];
      m_r[3] <= u_r[0] * w_r[2];
      m_r[4] <= u_r[0] * w_r[1];
      m_r[5] <= u_r[1] * w_r[0];
      last_r[1] <= last_r[0];
    end
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        c_r[i] <= tfn_pkg::CrossW'(m_r[2*i]) - tfn_pkg::CrossW'(m_r[2*i+1]);
      end
      last_r[2] <= last_r[1];
    end
    if (ld[3]) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i]  <= tfn_pkg::SqW'(mag[i]) * tfn_pkg::SqW'(mag[i]);
        neg_r[i] <= c_r[i][tfn_pkg::CrossW-1];
      end
      last_r[3] <= last_r[2];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = c_r[i][tfn_pkg::CrossW-1] ? tfn_pkg::MagW'(-c_r[i])
                                          : tfn_pkg::MagW'(c_r[i]);
    end
  end

  always_comb begin
    s_sum = tfn_pkg::SumW'(sq_r[0]) + tfn_pkg::SumW'(sq_r[1])
          + tfn_pkg::SumW'(sq_r[2]);
    it0_nxt.s = s_sum;
    it0_nxt.zero = (s_sum == '0);
    it0_nxt.last = last_r[3];
    for (int i = 0; i < 3; i++) begin
      it0_nxt.lane[i].r = $signed({{(tfn_pkg::ResW - tfn_pkg::SqW - tfn_pkg::FracShift){1'b0}},
                                   sq_r[i], {tfn_pkg::FracShift{1'b0}}})
                        - $signed({{(tfn_pkg::ResW - tfn_pkg::SumW){1'b0}}, s_sum});
      it0_nxt.lane[i].p = -$signed({{(tfn_pkg::ResW - tfn_pkg::SumW){1'b0}}, s_sum});
      it0_nxt.lane[i].k = '0;
      it0_nxt.lane[i].neg = neg_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[IT0]) begin
      it_r[0] <= it0_nxt;
    end
  end

  for (genvar g = 0; g < tfn_pkg::NumIter; g++) begin : g_iter
    tfn_iter #(
      .BIT(tfn_pkg::NumIter - 1 - g)
    ) u_iter (
      .clk(clk),
      .en (ld[IT0+1+g]),
      .d  (it_r[g]),
      .q_r(it_r[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (ld[NS-1]) begin
      for (int i = 0; i < 3; i++) begin
        if (it_r[tfn_pkg::NumIter].zero) begin
          o_r[i] <= '0;
        end else if (it_r[tfn_pkg::NumIter].lane[i].neg) begin
          o_r[i] <= -tfn_pkg::OutW'(it_r[tfn_pkg::NumIter].lane[i].k);
        end else begin
          o_r[i] <= tfn_pkg::OutW'(it_r[tfn_pkg::NumIter].lane[i].k);
        end
      end
      o_last_r <= it_r[tfn_pkg::NumIter].last;
    end
  end

  assign out_tvalid = v_r[NS-1];
  assign out_tdata  = {o_r[2], o_r[1], o_r[0]};
  assign out_tlast  = o_last_r;

endmodule

@@ bench/tb_triangle_facet_normal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_facet_normal
// Self-checking bench for the triangle facet normal pipeline.
// ----------------------------------------------------------------------------
// A directed table of triangles (extremes, degenerate cases, axis-aligned
// facets) is followed by random triangles under several idle and stall phases. Every
// result is compared with a bit-exact normal computed in the bench.
// ----------------------------------------------------------------------------
module tb_triangle_facet_normal;

  localparam int NumRandom = 1730;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;

  typedef struct {
    logic [15:0] c[9];
    logic        last;
  } tri_t;

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        last;
  } normal_t;

  typedef struct {
    tri_t    t;
    bit      known;
    normal_t n;
  } row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic         out_tlast;

  normal_t pending_normals[$];
  int      fails;
  int      cycles;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_off;
  row_t    rows[$];

  triangle_facet_normal u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [15:0] unit_part(longint signed comp, logic [69:0] sq_sum);
    logic [99:0] lhs;
    logic [99:0] rhs;
    logic [67:0] mag;
    logic [14:0] k;
    logic [15:0] trial;
    logic [31:0] odd;
    mag = (comp < 0) ? -comp : comp;
    lhs = (100'(mag) * 100'(mag)) << 30;
    k = 0;
    for (int b = 14; b >= 0; b--) begin
      trial = {1'b0, k} | (16'd1 << b);
      if (trial <= 16'd16384) begin
        odd = 2 * trial - 1;
        rhs = 100'(sq_sum) * 100'(odd) * 100'(odd);
        if (lhs >= rhs) k = trial[14:0];
      end
    end
    trial = {1'b0, k};
    return (comp < 0) ? -trial : trial;
  endfunction

  function automatic normal_t facet_normal(tri_t t);
    longint signed v[9];
    longint signed ux, uy, uz, wx, wy, wz, px, py, pz;
    logic [69:0] s;
    logic [69:0] mx, my, mz;
    normal_t n;
    for (int i = 0; i < 9; i++) v[i] = longint'($signed(t.c[i]));
    ux = v[3] - v[0]; uy = v[4] - v[1]; uz = v[5] - v[2];
    wx = v[6] - v[0]; wy = v[7] - v[1]; wz = v[8] - v[2];
    px = uy * wz - uz * wy;
    py = uz * wx - ux * wz;
    pz = ux * wy - uy * wx;
    mx = 70'((px < 0) ? -px : px);
    my = 70'((py < 0) ? -py : py);
    mz = 70'((pz < 0) ? -pz : pz);
    s = mx * mx + my * my + mz * mz;
    if (s == 0) begin
      n.nx = 0; n.ny = 0; n.nz = 0;
    end else begin
      n.nx = unit_part(px, s);
      n.ny = unit_part(py, s);
      n.nz = unit_part(pz, s);
    end
    n.last = t.last;
    return n;
  endfunction

  function automatic tri_t make_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                                    int c0, int c1, int c2, bit last);
    tri_t t;
    t.c[0] = 16'(a0); t.c[1] = 16'(a1); t.c[2] = 16'(a2);
    t.c[3] = 16'(b0); t.c[4] = 16'(b1); t.c[5] = 16'(b2);
    t.c[6] = 16'(c0); t.c[7] = 16'(c1); t.c[8] = 16'(c2);
    t.last = last;
    return t;
  endfunction

  task automatic add_row(tri_t t, bit known, int nx, int ny, int nz);
    row_t r;
    r.t = t;
    r.known = known;
    r.n.nx = 16'(nx); r.n.ny = 16'(ny); r.n.nz = 16'(nz); r.n.last = t.last;
    rows.push_back(r);
  endtask

  function automatic tri_t random_tri();
    tri_t t;
    int sh;
    sh = $urandom_range(0, 15);
    for (int i = 0; i < 9; i++) begin
      case ($urandom_range(0, 9))
        0: t.c[i] = 16'h8000;
        1: t.c[i] = 16'h7fff;
        2, 3: t.c[i] = 16'($signed(16'($urandom)) >>> sh);
        default: t.c[i] = 16'($urandom);
      endcase
    end
    if ($urandom_range(0, 19) == 0) begin
      for (int i = 0; i < 3; i++) t.c[6 + i] = 16'(t.c[i] + 2 * (t.c[3 + i] - t.c[i]));
    end
    t.last = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic send_tri(tri_t t);
    logic [143:0] d;
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < 9; i++) d[16 * i +: 16] = t.c[i];
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tlast <= t.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_normals.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) pending_normals.push_back(facet_normal(
      make_tri($signed(in_tdata[15:0]), $signed(in_tdata[31:16]),
               $signed(in_tdata[47:32]), $signed(in_tdata[63:48]),
               $signed(in_tdata[79:64]), $signed(in_tdata[95:80]),
               $signed(in_tdata[111:96]), $signed(in_tdata[127:112]),
               $signed(in_tdata[143:128]), in_tlast)));
  end

  always @(posedge clk) begin
    normal_t exp_n;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_normals.size() == 0) begin
        $error("normal with no triangle pending: %h", out_tdata);
        fails++;
      end else begin
        exp_n = pending_normals.pop_front();
        if (out_tdata[15:0] !== exp_n.nx) begin
          $error("nx expected %h actual %h", exp_n.nx, out_tdata[15:0]);
          fails++;
        end
        if (out_tdata[31:16] !== exp_n.ny) begin
          $error("ny expected %h actual %h", exp_n.ny, out_tdata[31:16]);
          fails++;
        end
        if (out_tdata[47:32] !== exp_n.nz) begin
          $error("nz expected %h actual %h", exp_n.nz, out_tdata[47:32]);
          fails++;
        end
        if (out_tlast !== exp_n.last) begin
          $error("normal_last expected %b actual %b", exp_n.last, out_tlast);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_tready <= !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    row_t r;
    normal_t n;
    fails = 0;
    cycles = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Degenerate triangles give a zero normal.
    add_row(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0);
    add_row(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                     -32768, -32768, -32768, 1), 1, 0, 0, 0);
    add_row(make_tri(0, 0, 0, 100, 200, 300, 200, 400, 600, 0), 1, 0, 0, 0);
    add_row(make_tri(5, 5, 5, 5, 5, 5, 9, 1, 2, 1), 1, 0, 0, 0);
    // Axis-aligned facets give exact unit components.
    add_row(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0), 1, 0, 0, 16384);
    add_row(make_tri(0, 0, 0, 0, 4096, 0, 4096, 0, 0, 1), 1, 0, 0, -16384);
    add_row(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1, 16384, 0, 0);
    add_row(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0, 0), 1, 0, 16384, 0);
    add_row(make_tri(-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0, 1),
            1, 0, 0, 16384);
    // Full-range extremes and mixed cases go through the predictor.
    add_row(make_tri(-32768, -32768, -32768, 32767, -32768, 32767,
                     32767, 32767, -32768, 0), 0, 0, 0, 0);
    add_row(make_tri(32767, 32767, 32767, -32768, 32767, -32768,
                     -32768, -32768, 32767, 1), 0, 0, 0, 0);
    add_row(make_tri(-32768, 0, 32767, 32767, -32768, 0, 0, 32767, -32768, 0),
            0, 0, 0, 0);
    add_row(make_tri(0, 0, 0, 1, 0, 0, 1, 1, 1, 0), 0, 0, 0, 0);
    add_row(make_tri(0, 0, 0, 1, 2, 3, 3, 1, 2, 1), 0, 0, 0, 0);
    add_row(make_tri(12, -7, 300, -9000, 450, 21, 77, 32000, -15000, 0), 0, 0, 0, 0);
    add_row(make_tri(0, 0, 0, 32767, 1, 0, -32768, 1, 1, 1), 0, 0, 0, 0);

    foreach (rows[i]) begin
      if (rows[i].known) begin
        n = facet_normal(rows[i].t);
        if (n !== rows[i].n) begin
          $error("predictor row %0d nx %h ny %h nz %h", i, n.nx, n.ny, n.nz);
          fails++;
        end
      end
      send_tri(rows[i].t);
    end
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        3: begin send_idle_pct = 36; recv_stall_pct = 36; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_off = 200; end
      endcase
      for (int i = 0; i < NumRandom / 5; i++) send_tri(random_tri());
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tfn_pkg.sv
rtl/tfn_iter.sv
rtl/triangle_facet_normal.sv
bench/tb_triangle_facet_normal.sv
